/* rtl/core/wttc_pkg.sv */
// ----------------------------------------------------------------------------
// wttc_pkg
// Shared types and constants of the word-table text codec.
// ----------------------------------------------------------------------------
package wttc_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int MAX_WORD_DEF      = 32;

    localparam int PL_W = 6;                      // probe limit register width
    localparam logic [PL_W-1:0] PL_RESET = 6'd20;

    localparam logic KIND_COMPRESS   = 1'b0;
    localparam logic KIND_DECOMPRESS = 1'b1;

    localparam logic [7:0] TOKEN_FLAG = 8'h80;

    // one input item as queued between front and back
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
        logic       alnum;
    } cmd_t;

    // back status seen by the front
    typedef struct packed {
        logic clearing;
    } back_stat_t;

endpackage

/* rtl/core/wttc_ram.sv */
// ----------------------------------------------------------------------------
// wttc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module wttc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/wttc_front.sv */
// ----------------------------------------------------------------------------
// wttc_front
// Input side: takes items, marks letters and digits, and queues them.
// ----------------------------------------------------------------------------
module wttc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // data_byte
    input  logic                  s_tuser,   // kind
    input  logic                  s_tlast,   // last
    input  wttc_pkg::back_stat_t  stat,
    output logic                  q_valid,
    output wttc_pkg::cmd_t        q_cmd,
    input  logic                  q_pop
);
    import wttc_pkg::*;

    cmd_t       buf_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    cmd_t       in_cmd;
    logic       push;

    always_comb begin
        in_cmd.kind  = s_tuser;
        in_cmd.data  = s_tdata;
        in_cmd.last  = s_tlast;
        in_cmd.alnum = (s_tdata >= 8'h30 && s_tdata <= 8'h39) ||
                       (s_tdata >= 8'h41 && s_tdata <= 8'h5A) ||
                       (s_tdata >= 8'h61 && s_tdata <= 8'h7A);
    end

    assign s_tready = (cnt_reg != 2'd2) && !stat.clearing;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = buf_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (q_pop) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

/* rtl/core/wttc_back.sv */
// ----------------------------------------------------------------------------
// wttc_back
// Execution side: word gathering, hashing, table probe and insert, token
// expansion, and the output register.
// ----------------------------------------------------------------------------
module wttc_back #(
    parameter int TABLE_ENTRIES = wttc_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_WORD      = wttc_pkg::MAX_WORD_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [wttc_pkg::PL_W-1:0]  cfg_wdata,
    input  logic                       q_valid,
    input  wttc_pkg::cmd_t             q_cmd,
    output logic                       q_pop,
    output wttc_pkg::back_stat_t       stat,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);
    import wttc_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int KW = $clog2(MAX_WORD + 1);
    localparam logic [IW:0]     T_I   = (IW+1)'(TABLE_ENTRIES);
    localparam logic [15:0]     T_16  = 16'(TABLE_ENTRIES);
    localparam logic [IW-1:0]   CLR_END = IW'(TABLE_ENTRIES - 1);
    localparam logic [5:0]      MAXW  = 6'(MAX_WORD);
    // reciprocal for an exact 32-bit remainder by the table size
    localparam int              SH    = 32 + IW;
    localparam logic [32:0]     RECIP = 33'((64'd1 << SH) / 64'(TABLE_ENTRIES) + 64'd1);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_HASH  = 12'b0000_0000_0100,
        S_MOD   = 12'b0000_0000_1000,
        S_PROBE = 12'b0000_0001_0000,
        S_CMP   = 12'b0000_0010_0000,
        S_INS   = 12'b0000_0100_0000,
        S_TOK   = 12'b0000_1000_0000,
        S_RAW   = 12'b0001_0000_0000,
        S_DEC   = 12'b0010_0000_0000,
        S_EXP   = 12'b0100_0000_0000,
        S_SPARE = 12'b1000_0000_0000
    } state_t;

    state_t         state_reg, state_next;
    logic [PL_W-1:0] pl_reg, pl_next;
    logic [5:0]     wl_reg, wl_next;
    logic [5:0]     len_reg, len_next;
    logic [5:0]     k_reg, k_next;
    logic [IW:0]    i_reg, i_next;
    logic [5:0]     j_reg, j_next;
    logic [31:0]    h_reg, h_next;
    logic [64:0]    prod_reg, prod_next;
    logic           ph_reg, ph_next;
    logic           tok2_reg, tok2_next;
    logic [6:0]     th_reg, th_next;
    logic           pend_reg, pend_next;
    logic [IW-1:0]  clr_reg, clr_next;
    logic           ov_reg, ov_next;
    logic [7:0]     ob_reg, ob_next;
    logic           ol_reg, ol_next;
    logic           oe_reg, oe_next;

    // ram ports
    logic           wb_we;
    logic [6:0]     wb_wdata, wb_rdata;
    logic           el_we;
    logic [IW-1:0]  el_waddr;
    logic [5:0]     el_wdata, el_rdata;
    logic           by_we;
    logic [6:0]     by_rdata;

    // helpers
    logic           out_free;
    logic           emit, e_last, e_err;
    logic [7:0]     e_byte;
    logic           in_rng;
    logic           skip;
    logic [IW:0]    ex_i;
    logic [6:0]     ex_j;
    logic           ex_raw;
    logic [31:0]    quo;
    logic [31:0]    rem_full;
    logic [15:0]    idx16;
    logic [15:0]    ip;
    logic [5:0]     k_inc;
    logic           k_end;

    wttc_ram #(.WIDTH(7), .DEPTH(MAX_WORD + 1)) u_word_ram (
        .aclk  (aclk),
        .we    (wb_we),
        .waddr (wl_reg[KW-1:0]),
        .wdata (wb_wdata),
        .raddr (k_reg[KW-1:0]),
        .rdata (wb_rdata)
    );

    wttc_ram #(.WIDTH(6), .DEPTH(TABLE_ENTRIES)) u_len_ram (
        .aclk  (aclk),
        .we    (el_we),
        .waddr (el_waddr),
        .wdata (el_wdata),
        .raddr (i_reg[IW-1:0]),
        .rdata (el_rdata)
    );

    // each entry owns a row of 2**KW bytes
    wttc_ram #(.WIDTH(7), .DEPTH(TABLE_ENTRIES << KW)) u_byte_ram (
        .aclk  (aclk),
        .we    (by_we),
        .waddr ({i_reg[IW-1:0], k_reg[KW-1:0]}),
        .wdata (wb_rdata),
        .raddr ({i_reg[IW-1:0], k_reg[KW-1:0]}),
        .rdata (by_rdata)
    );

    assign out_free       = !ov_reg || m_tready;
    assign stat.clearing  = (state_reg == S_CLEAR);
    assign m_tvalid       = ov_reg;
    assign m_tdata        = ob_reg;
    assign m_tlast        = ol_reg;
    assign m_tuser        = oe_reg;

    always_comb begin
        in_rng   = (i_reg < T_I) && (j_reg < pl_reg);
        skip     = (i_reg[7:0] == 8'd0);
        ex_i     = i_reg + (IW+1)'(skip);
        ex_j     = {1'b0, j_reg} + 7'(skip);
        ex_raw   = (ex_i >= T_I) || (ex_j >= {1'b0, pl_reg});
        quo      = 32'(prod_reg >> SH);
        rem_full = h_reg - quo * 32'(TABLE_ENTRIES);
        idx16    = {1'b0, th_reg, q_cmd.data};
        ip       = 16'(i_reg);
        k_inc    = k_reg + 6'd1;
        k_end    = (k_inc == len_reg);
    end

    always_comb begin
        state_next = state_reg;
        pl_next    = cfg_we ? cfg_wdata : pl_reg;
        wl_next    = wl_reg;
        len_next   = len_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        h_next     = h_reg;
        prod_next  = prod_reg;
        ph_next    = ph_reg;
        tok2_next  = tok2_reg;
        th_next    = th_reg;
        pend_next  = pend_reg;
        clr_next   = clr_reg;
        q_pop      = 1'b0;
        wb_we      = 1'b0;
        wb_wdata   = q_cmd.data[6:0];
        el_we      = 1'b0;
        el_waddr   = i_reg[IW-1:0];
        el_wdata   = len_reg;
        by_we      = 1'b0;
        emit       = 1'b0;
        e_byte     = 8'd0;
        e_last     = 1'b0;
        e_err      = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                el_we    = 1'b1;
                el_waddr = clr_reg;
                el_wdata = 6'd0;
                clr_next = clr_reg + IW'(1);
                if (clr_reg == CLR_END) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    if (q_cmd.kind == KIND_COMPRESS) begin
                        if (q_cmd.alnum && wl_reg < MAXW && !q_cmd.last) begin
                            wb_we   = 1'b1;
                            wl_next = wl_reg + 6'd1;
                        end else if (wl_reg != 6'd0 || (q_cmd.alnum && wl_reg < MAXW)) begin
                            // word ends here: store the byte and finish it
                            wb_we      = 1'b1;
                            len_next   = wl_reg + 6'd1;
                            wl_next    = 6'd0;
                            k_next     = 6'd0;
                            ph_next    = 1'b0;
                            h_next     = 32'd0;
                            state_next = (wl_reg + 6'd1 <= 6'd2) ? S_RAW : S_HASH;
                        end else begin
                            emit   = 1'b1;
                            e_byte = {1'b0, q_cmd.data[6:0]};
                            e_last = 1'b1;
                        end
                    end else begin
                        if (q_cmd.last) begin
                            wl_next = 6'd0;
                        end
                        if (pend_reg) begin
                            pend_next = 1'b0;
                            if (idx16 >= T_16) begin
                                emit   = 1'b1;
                                e_err  = 1'b1;
                                e_last = 1'b1;
                            end else begin
                                i_next     = (IW+1)'(idx16);
                                ph_next    = 1'b0;
                                state_next = S_DEC;
                            end
                        end else if (q_cmd.data[7]) begin
                            if (q_cmd.last) begin
                                emit   = 1'b1;
                                e_err  = 1'b1;
                                e_last = 1'b1;
                            end else begin
                                th_next   = q_cmd.data[6:0];
                                pend_next = 1'b1;
                            end
                        end else begin
                            emit   = 1'b1;
                            e_byte = q_cmd.data;
                            e_last = 1'b1;
                        end
                    end
                    if (q_cmd.last) begin
                        pend_next = 1'b0;
                    end
                end
            end
            S_HASH: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    h_next = h_reg + (h_reg << 5) + {25'd0, wb_rdata};
                    k_next = k_inc;
                    if (k_end) begin
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD: begin
                // reciprocal multiply, then subtract the quotient times the size
                if (!ph_reg) begin
                    prod_next = {33'd0, h_reg} * {32'd0, RECIP};
                    ph_next   = 1'b1;
                end else begin
                    i_next     = {1'b0, rem_full[IW-1:0]};
                    j_next     = 6'd0;
                    ph_next    = 1'b0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!ph_reg && in_rng) begin
                    ph_next = 1'b1;
                end else if (ph_reg && (el_rdata != 6'd0 || skip)) begin
                    ph_next = 1'b0;
                    if (el_rdata == len_reg) begin
                        k_next     = 6'd0;
                        state_next = S_CMP;
                    end else begin
                        i_next = i_reg + (IW+1)'(1);
                        j_next = j_reg + 6'd1;
                    end
                end else begin
                    // free slot found or probing stopped
                    ph_next = 1'b0;
                    k_next  = 6'd0;
                    if (ex_raw) begin
                        state_next = S_RAW;
                    end else begin
                        i_next     = ex_i;
                        j_next     = ex_j[5:0];
                        state_next = S_INS;
                    end
                end
            end
            S_CMP: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    if (wb_rdata == by_rdata) begin
                        k_next = k_inc;
                        if (k_end) begin
                            tok2_next  = 1'b0;
                            state_next = S_TOK;
                        end
                    end else begin
                        i_next     = i_reg + (IW+1)'(1);
                        j_next     = j_reg + 6'd1;
                        state_next = S_PROBE;
                    end
                end
            end
            S_INS: begin
                el_we   = (k_reg == 6'd0) && !ph_reg;
                ph_next = !ph_reg;
                if (ph_reg) begin
                    by_we  = 1'b1;
                    k_next = k_inc;
                    if (k_end) begin
                        tok2_next  = 1'b0;
                        state_next = S_TOK;
                    end
                end
            end
            S_TOK: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (!tok2_reg) begin
                        e_byte    = TOKEN_FLAG | {1'b0, ip[14:8]};
                        tok2_next = 1'b1;
                    end else begin
                        e_byte     = ip[7:0];
                        e_last     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_RAW: begin
                if (!ph_reg) begin
                    ph_next = 1'b1;
                end else if (out_free) begin
                    emit    = 1'b1;
                    e_byte  = {1'b0, wb_rdata};
                    e_last  = k_end;
                    k_next  = k_inc;
                    ph_next = 1'b0;
                    if (k_end) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DEC: begin
                if (!ph_reg) begin
                    ph_next = 1'b1;
                end else if (el_rdata == 6'd0) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        e_err      = 1'b1;
                        e_last     = 1'b1;
                        ph_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                end else begin
                    len_next   = el_rdata;
                    k_next     = 6'd0;
                    ph_next    = 1'b0;
                    state_next = S_EXP;
                end
            end
            S_EXP: begin
                if (!ph_reg) begin
                    ph_next = 1'b1;
                end else if (out_free) begin
                    emit    = 1'b1;
                    e_byte  = {1'b0, by_rdata};
                    e_last  = k_end;
                    k_next  = k_inc;
                    ph_next = 1'b0;
                    if (k_end) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        ov_next = ov_reg && !m_tready;
        ob_next = ob_reg;
        ol_next = ol_reg;
        oe_next = oe_reg;
        if (emit) begin
            ov_next = 1'b1;
            ob_next = e_byte;
            ol_next = e_last;
            oe_next = e_err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            pl_reg    <= PL_RESET;
            wl_reg    <= 6'd0;
            pend_reg  <= 1'b0;
            th_reg    <= 7'd0;
            clr_reg   <= '0;
            ph_reg    <= 1'b0;
            tok2_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            pl_reg    <= pl_next;
            wl_reg    <= wl_next;
            pend_reg  <= pend_next;
            th_reg    <= th_next;
            clr_reg   <= clr_next;
            ph_reg    <= ph_next;
            tok2_reg  <= tok2_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg  <= len_next;
        k_reg    <= k_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        h_reg    <= h_next;
        prod_reg <= prod_next;
        ob_reg   <= ob_next;
        ol_reg   <= ol_next;
        oe_reg   <= oe_next;
    end

    a_word_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wl_reg <= MAXW)
        else $error("word length beyond limit");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == S_IDLE && out_free))
        else $error("item taken while busy");

    a_ins_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS) |-> (i_reg < T_I && i_reg[7:0] != 8'd0))
        else $error("insert into reserved or out-of-range slot");

endmodule

/* rtl/core/word_table_text_codec.sv */
// ----------------------------------------------------------------------------
// word_table_text_codec
// Hashed word-dictionary byte-stream codec with a shared table.
// ----------------------------------------------------------------------------
// After reset the block sweeps the entry-length table, one entry a cycle,
// and takes no item until that is done. A pass-through byte is held in the
// input queue and then in the output register, and bytes that pass through
// or cause no result flow at one item a cycle while the output is not
// stalled. At a word end the back part hashes the word bytes, takes the
// index remainder (a reciprocal multiply), then probes slots and compares
// bytes, and stores the word in a free slot; a token leaves at one byte a
// cycle while the output is not stalled, and a raw word byte by byte. Token
// expansion does a length lookup and then reads each emitted byte. The
// registered memory reads pace these steps, and the back part waits while
// the output is stalled. A two-item queue lets input and output stall
// independently.
module word_table_text_codec #(
    parameter int TABLE_ENTRIES = wttc_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_WORD      = wttc_pkg::MAX_WORD_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [wttc_pkg::PL_W-1:0] cfg_wdata,   // probe_limit
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,     // data_byte
    input  logic                      s_tuser,     // kind
    input  logic                      s_tlast,     // last
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,     // out_byte
    output logic                      m_tuser,     // error
    output logic                      m_tlast      // out_last
);
    import wttc_pkg::*;

    cmd_t       q_cmd;
    logic       q_valid, q_pop;
    back_stat_t stat;

    wttc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    wttc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_WORD      (MAX_WORD)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

/* verif/word_table_text_codec_checker.sv */
// ----------------------------------------------------------------------------
// word_table_text_codec_checker
// Watches both streams of the codec, predicts every result and compares.
// ----------------------------------------------------------------------------
module word_table_text_codec_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [wttc_pkg::PL_W-1:0] cfg_wdata,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [7:0]                s_tdata,
    input  logic                      s_tuser,
    input  logic                      s_tlast,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [7:0]                m_tdata,
    input  logic                      m_tuser,
    input  logic                      m_tlast,
    output int                        fail_count,
    output int                        pending_count,
    output int                        checked_count,
    output logic [11:0]               known_index,
    output logic                      known_valid
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = wttc_pkg::TABLE_ENTRIES_DEF;
    localparam int WMAX    = wttc_pkg::MAX_WORD_DEF;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       error;
    } codec_out_t;

    logic [wttc_pkg::PL_W-1:0] probe_limit;
    logic [6:0] word_buf [0:WMAX];
    logic [5:0] word_len;
    logic [5:0] entry_len [0:ENTRIES-1];
    logic [6:0] entry_bytes [0:ENTRIES-1][0:WMAX];
    logic       tok_pend;
    logic [6:0] tok_high;

    codec_out_t step_out[$];
    codec_out_t expected_out[$];

    function automatic void push_byte(logic [7:0] b, logic err);
        codec_out_t r;
        r.out_byte = b;
        r.out_last = 1'b0;
        r.error    = err;
        step_out.push_back(r);
    endfunction

    function automatic void push_raw_word();
        for (int k = 0; k < word_len; k++)
            push_byte({1'b0, word_buf[k]}, 1'b0);
    endfunction

    function automatic void push_token(int idx);
        known_index = idx[11:0];
        known_valid = 1'b1;
        push_byte({1'b1, idx[14:8]}, 1'b0);
        push_byte(idx[7:0], 1'b0);
    endfunction

    function automatic void finish_word();
        logic [31:0] h;
        int i, j, len;
        bit same;
        h = 0;
        len = word_len;
        if (len <= 2) begin
            push_raw_word();
            return;
        end
        for (int k = 0; k < len; k++)
            h = h * 33 + word_buf[k];
        i = h % ENTRIES;
        j = 0;
        while (i < ENTRIES && (entry_len[i] != 0 || i[7:0] == 0) && j < probe_limit) begin
            if (entry_len[i] == len) begin
                same = 1;
                for (int k = 0; k < len; k++)
                    if (entry_bytes[i][k] != word_buf[k]) same = 0;
                if (same) begin
                    push_token(i);
                    return;
                end
            end
            i++;
            j++;
        end
        // an index with a zero low byte is reserved
        if (i[7:0] == 0) begin
            i++;
            j++;
        end
        if (i >= ENTRIES || j >= probe_limit) begin
            push_raw_word();
            return;
        end
        entry_len[i] = len[5:0];
        for (int k = 0; k < len; k++)
            entry_bytes[i][k] = word_buf[k];
        push_token(i);
    endfunction

    function automatic void predict_item(logic kind, logic [7:0] c, logic last);
        int idx;
        bit alnum;
        step_out.delete();
        if (kind == wttc_pkg::KIND_COMPRESS) begin
            alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                    (c >= "a" && c <= "z");
            if (!alnum || word_len >= WMAX) begin
                if (word_len != 0) begin
                    word_buf[word_len] = c[6:0];
                    word_len++;
                    finish_word();
                    word_len = 0;
                end else begin
                    push_byte({1'b0, c[6:0]}, 1'b0);
                end
            end else begin
                word_buf[word_len] = c[6:0];
                word_len++;
            end
            if (last && word_len != 0) begin
                finish_word();
                word_len = 0;
            end
        end else if (tok_pend) begin
            idx = {tok_high, c};
            tok_pend = 0;
            if (idx >= ENTRIES || entry_len[idx] == 0) begin
                push_byte(8'h00, 1'b1);
            end else begin
                for (int k = 0; k < entry_len[idx]; k++)
                    push_byte({1'b0, entry_bytes[idx][k]}, 1'b0);
            end
        end else if (c[7]) begin
            // first token byte on the final item is a truncated token
            if (last) push_byte(8'h00, 1'b1);
            else begin
                tok_high = c[6:0];
                tok_pend = 1;
            end
        end else begin
            push_byte(c, 1'b0);
        end
        if (last) begin
            word_len = 0;
            tok_pend = 0;
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].out_last = 1'b1;
        foreach (step_out[n]) expected_out.push_back(step_out[n]);
    endfunction

    always @(posedge aclk) begin
        codec_out_t e;
        if (!aresetn) begin
            probe_limit = wttc_pkg::PL_RESET;
            word_len = 0;
            tok_pend = 0;
            tok_high = 0;
            known_valid = 1'b0;
            known_index = '0;
            for (int i = 0; i < ENTRIES; i++) entry_len[i] = 0;
            expected_out.delete();
        end else begin
            if (cfg_we) probe_limit = cfg_wdata;
            if (m_tvalid && m_tready) begin
                checked_count++;
                if (expected_out.size() == 0) begin
                    $error("result with nothing expected: byte %h", m_tdata);
                    fail_count++;
                end else begin
                    e = expected_out.pop_front();
                    if (m_tdata !== e.out_byte) begin
                        $error("out_byte expected %h actual %h", e.out_byte, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== e.out_last) begin
                        $error("out_last expected %b actual %b", e.out_last, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser !== e.error) begin
                        $error("error expected %b actual %b", e.error, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata, s_tlast);
        end
        pending_count = expected_out.size();
    end

    initial begin
        fail_count = 0;
        checked_count = 0;
        pending_count = 0;
        known_valid = 1'b0;
        known_index = '0;
    end
endmodule

/* verif/word_table_text_codec_test.sv */
// ----------------------------------------------------------------------------
// word_table_text_codec_test
// Drives compress and decompress byte streams with random stalls through the
// codec under several probe limits; the checker predicts and compares.
// ----------------------------------------------------------------------------
module word_table_text_codec_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [wttc_pkg::PL_W-1:0] cfg_wdata;
    logic                      s_tvalid, s_tready, s_tuser, s_tlast;
    logic [7:0]                s_tdata;
    logic                      m_tvalid, m_tready, m_tuser, m_tlast;
    logic [7:0]                m_tdata;
    int                        fail_count, pending_count, checked_count;
    logic [11:0]               known_index;
    logic                      known_valid;

    int  items_sent;
    int  stall_left;
    bit  idle_on;
    logic [7:0] vocab [0:7][0:39];
    int  vocab_len [0:7];

    word_table_text_codec uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    word_table_text_codec_checker checker_i (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending_count(pending_count),
        .checked_count(checked_count),
        .known_index(known_index), .known_valid(known_valid)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver stalls in random bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 19);
        end
    end

    function automatic logic [7:0] pick_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return 8'("0" + r);
        if (r < 36) return 8'("A" + r - 10);
        return 8'("a" + r - 36);
    endfunction

    function automatic logic [7:0] pick_delim();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"));
        return c;
    endfunction

    task automatic send_item(logic kind, logic [7:0] data, logic last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_word(int w, logic last);
        for (int k = 0; k < vocab_len[w]; k++)
            send_item(wttc_pkg::KIND_COMPRESS, vocab[w][k], 1'b0);
        send_item(wttc_pkg::KIND_COMPRESS, pick_delim(), last);
    endtask

    task automatic send_token(logic [14:0] idx, logic last);
        send_item(wttc_pkg::KIND_DECOMPRESS, {1'b1, idx[14:8]}, 1'b0);
        send_item(wttc_pkg::KIND_DECOMPRESS, idx[7:0], last);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        // a word may still be in the works with nothing expected
        repeat (3000) @(negedge aclk);
    endtask

    task automatic set_probe_limit(logic [wttc_pkg::PL_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int r, stop;
        stop = items_sent + n;
        while (items_sent < stop) begin
            r = $urandom_range(0, 9);
            if (r < 5) send_word($urandom_range(0, 7), $urandom_range(0, 5) == 0);
            else if (r < 8) begin
                if (known_valid && r < 7) send_token({3'b000, known_index}, $urandom_range(0, 3) == 0);
                else send_token(15'($urandom_range(0, 32767)), $urandom_range(0, 3) == 0);
            end else
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        stall_left = 0;
        idle_on = 1'b1;
        items_sent = 0;
        for (int w = 0; w < 8; w++) begin
            // one entry longer than a word so the long-word split is reached
            vocab_len[w] = (w == 7) ? 35 : $urandom_range(1, 6);
            for (int k = 0; k < vocab_len[w]; k++) vocab[w][k] = pick_alnum();
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: edge bytes, bad and truncated tokens, hit on repeat
        send_item(wttc_pkg::KIND_COMPRESS, 8'h00, 1'b0);
        send_item(wttc_pkg::KIND_COMPRESS, 8'h80, 1'b0);
        send_item(wttc_pkg::KIND_COMPRESS, 8'hFF, 1'b1);
        send_item(wttc_pkg::KIND_COMPRESS, "a", 1'b0);
        send_item(wttc_pkg::KIND_COMPRESS, "Z", 1'b1);
        send_item(wttc_pkg::KIND_COMPRESS, "9", 1'b0);
        send_item(wttc_pkg::KIND_COMPRESS, "0", 1'b0);
        send_item(wttc_pkg::KIND_COMPRESS, "z", 1'b0);
        send_item(wttc_pkg::KIND_COMPRESS, 8'h00, 1'b0);
        send_item(wttc_pkg::KIND_COMPRESS, "9", 1'b0);
        send_item(wttc_pkg::KIND_COMPRESS, "0", 1'b0);
        send_item(wttc_pkg::KIND_COMPRESS, "z", 1'b1);
        send_item(wttc_pkg::KIND_DECOMPRESS, 8'h7F, 1'b0);
        send_item(wttc_pkg::KIND_DECOMPRESS, 8'h85, 1'b1);
        send_token(15'h7FFF, 1'b0);
        send_token(15'h0001, 1'b0);
        // word left open then cut by a decompress last
        send_item(wttc_pkg::KIND_COMPRESS, "Q", 1'b0);
        send_item(wttc_pkg::KIND_DECOMPRESS, 8'h41, 1'b1);
        send_word(7, 1'b1);
        // sender holds off until every result is back
        drain();
        if (known_valid) send_token({3'b000, known_index}, 1'b1);

        random_phase(45);
        set_probe_limit(6'd63);
        random_phase(45);
        set_probe_limit(6'd0);
        random_phase(30);
        set_probe_limit(6'd1);
        random_phase(40);
        set_probe_limit(6'd32);
        random_phase(20);
        idle_on = 1'b0;
        random_phase(20);
        s_tvalid <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (3000) @(negedge aclk);
        $display("sent %0d compress/decompress bytes over probe limits 20, 63, 0, 1, 32",
                 items_sent);
        $display("checked %0d result bytes including tokens, hits and error results",
                 checked_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/wttc_pkg.sv
rtl/core/wttc_ram.sv
rtl/core/wttc_front.sv
rtl/core/wttc_back.sv
rtl/core/word_table_text_codec.sv
verif/word_table_text_codec_checker.sv
verif/word_table_text_codec_test.sv
